FILE: rtl/rmi_pkg.sv
// Shared types and constants for the range migration interpolator.
// Holds the input and result item structs, command codes and register indexes.
// No dependencies.
package rmi_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_COEF   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_SHIFT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS     = 2'd3;

  localparam logic [10:0] NUM_ROWS_RESET = 11'd1024;
  localparam logic [10:0] NUM_COLS_RESET = 11'd1024;

  typedef struct packed {
    logic               command;
    logic [9:0]         row;
    logic [9:0]         az_bin;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;
    logic               out_of_range;
    logic [9:0]         row_echo;
  } out_item_t;

endpackage

FILE: rtl/range_migration_interpolator_core.sv
// Range cell migration correction for one azimuth column, linear interpolation.
// Top level: column store, shift computation, interpolation and output register.
// Depends on rmi_pkg.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | rmi_pkg::in_item_t
//   out     | output    | out_valid / out_ready| rmi_pkg::out_item_t
//   cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// A write puts the sample into the store at the transfer edge when its row is below ROWS.
// A read steps through squaring, the split coefficient multiply, saturation, mapping, two reads
// of the single-port store and the interpolation; one that maps out of range skips the reads and the interpolation.
// The store needs no clearing pass after reset; rst clears only control and config.
// A finished result waits in the output register, and the block keeps taking
// items meanwhile; a read stalls in its last step only while that register is full.
module range_migration_interpolator_core #(
  parameter int ROWS = 1024,
  parameter int COLS = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rmi_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rmi_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [rmi_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rmi_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int S   = SAMPLE_BITS;
  localparam int F   = FRAC_BITS;
  localparam int AW  = $clog2(ROWS);
  localparam int RW  = $clog2(ROWS + 1);
  localparam int CW  = $clog2(COLS + 1);
  localparam int DW  = ((CW > 10) ? CW : 10) + 1;
  localparam int D2W = 2 * DW - 1;
  localparam int PPW = 16 + D2W;
  localparam int FW  = 32 + D2W;
  localparam int SW  = RW + F;
  localparam int RXW = (RW > 10) ? RW : 10;
  localparam int PW  = RXW + F + 2;
  localparam int NW  = S + F + 2;
  localparam logic [PW-1:0] ONE_P = PW'(1) << F;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQR  = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_SUM  = 9'b000001000,
    S_MAP  = 9'b000010000,
    S_RD0  = 9'b000100000,
    S_RD1  = 9'b001000000,
    S_LERP = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [31:0] shift_coef;
  logic        invert_shift;
  logic [10:0] num_rows;
  logic [10:0] num_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_coef   <= '0;
      invert_shift <= 1'b0;
      num_rows     <= rmi_pkg::NUM_ROWS_RESET;
      num_cols     <= rmi_pkg::NUM_COLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmi_pkg::REG_SHIFT_COEF:   shift_coef   <= cfg_data[31:0];
        rmi_pkg::REG_INVERT_SHIFT: invert_shift <= cfg_data[0];
        rmi_pkg::REG_NUM_ROWS:     num_rows     <= cfg_data[10:0];
        rmi_pkg::REG_NUM_COLS:     num_cols     <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Row and column counts saturated at the build sizes.
  logic [31:0]          rows_w, cols_w;
  logic [RW-1:0]        rows_c;
  logic [DW-2:0]        half_c, bin_c;
  logic signed [DW-1:0] d_c;
  logic [SW-1:0]        lim_c;

  assign rows_w = (32'(num_rows) > 32'(ROWS)) ? 32'(ROWS) : 32'(num_rows);
  assign cols_w = (32'(num_cols) > 32'(COLS)) ? 32'(COLS) : 32'(num_cols);
  assign rows_c = rows_w[RW-1:0];
  assign half_c = cols_w[DW-1:1];
  assign bin_c  = (DW-1)'(in_data.az_bin);
  assign d_c    = $signed({1'b0, bin_c}) - $signed({1'b0, half_c});
  assign lim_c  = {rows_c, {F{1'b0}}};

  // Column store: one port, registered read.
  logic [2*S-1:0] store [ROWS];
  logic [2*S-1:0] rdata;
  logic [2*S-1:0] wdata;
  logic [AW-1:0]  mem_addr;
  logic           mem_we, mem_re;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= wdata;
    end
    if (mem_re) begin
      rdata <= store[mem_addr];
    end
  end

  logic in_fire, row_fits;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign row_fits = ({22'd0, in_data.row} < 32'(ROWS));
  assign wdata    = {S'($signed(in_data.sample_re)), S'($signed(in_data.sample_im))};

  // Datapath registers.
  logic [9:0]           row_q;
  logic signed [DW-1:0] d_q;
  logic [D2W-1:0]       d2_q;
  logic [PPW-1:0]       plo_q, phi_q;
  logic [SW-1:0]        shift_q;
  logic [AW-1:0]        idx0_q;
  logic [F-1:0]         w_q;
  logic                 oor_q;
  logic [S-1:0]         a_re_q, a_im_q;
  logic [NW-1:0]        prod_re_q, prod_im_q;

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = idx0_q;
    case (state)
      S_IDLE: begin
        mem_addr = AW'(in_data.row);
        mem_we   = in_fire && (in_data.command == rmi_pkg::CMD_WRITE) && row_fits;
      end
      S_RD0: mem_re = !oor_q;
      S_RD1: begin
        mem_addr = idx0_q + AW'(1);
        mem_re   = 1'b1;
      end
      default: ;
    endcase
  end

  // Shift and mapping arithmetic.
  logic signed [2*DW-1:0] sq_c;
  logic [FW-1:0]          full_c, fsh_c;
  logic signed [PW-1:0]   rowf_c, p_c, top_c;
  logic                   row_in_c;

  assign sq_c     = d_q * d_q;
  assign full_c   = {phi_q, 16'd0} + FW'(plo_q);
  assign fsh_c    = full_c >> (32 - F);
  assign row_in_c = (RXW'(row_q) < RXW'(rows_c));
  assign rowf_c   = $signed(PW'({row_q, {F{1'b0}}}));
  assign p_c      = invert_shift ? (rowf_c - $signed(PW'(shift_q)))
                                 : (rowf_c + $signed(PW'(shift_q)));
  assign top_c    = $signed(PW'(lim_c)) - $signed(ONE_P);

  // Interpolation arithmetic.
  logic signed [S:0]    diff_re_c, diff_im_c;
  logic signed [NW-1:0] mul_re_c, mul_im_c;
  logic [NW-1:0]        num_re_c, num_im_c;
  logic [S-1:0]         res_re_c, res_im_c;

  assign diff_re_c = $signed({rdata[2*S-1], rdata[2*S-1:S]}) - $signed({a_re_q[S-1], a_re_q});
  assign diff_im_c = $signed({rdata[S-1], rdata[S-1:0]}) - $signed({a_im_q[S-1], a_im_q});
  assign mul_re_c  = $signed({1'b0, w_q}) * diff_re_c;
  assign mul_im_c  = $signed({1'b0, w_q}) * diff_im_c;
  assign num_re_c  = {{2{a_re_q[S-1]}}, a_re_q, {F{1'b0}}} + prod_re_q;
  assign num_im_c  = {{2{a_im_q[S-1]}}, a_im_q, {F{1'b0}}} + prod_im_q;
  // An arithmetic shift by the fraction width is the floor of the quotient.
  assign res_re_c  = num_re_c[F+S-1:F];
  assign res_im_c  = num_im_c[F+S-1:F];

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire && (in_data.command == rmi_pkg::CMD_READ)) begin
            state <= S_SQR;
          end
        end
        S_SQR:  state <= S_MUL;
        S_MUL:  state <= S_SUM;
        S_SUM:  state <= S_MAP;
        S_MAP:  state <= S_RD0;
        S_RD0:  state <= oor_q ? S_DONE : S_RD1;
        S_RD1:  state <= S_LERP;
        S_LERP: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        row_q <= in_data.row;
        d_q   <= d_c;
      end
      S_SQR: d2_q <= sq_c[D2W-1:0];
      S_MUL: begin
        // The 32-bit coefficient is split so that each product stays narrow.
        plo_q <= PPW'(shift_coef[15:0]) * PPW'(d2_q);
        phi_q <= PPW'(shift_coef[31:16]) * PPW'(d2_q);
      end
      S_SUM: shift_q <= (fsh_c > FW'(lim_c)) ? lim_c : fsh_c[SW-1:0];
      S_MAP: begin
        oor_q  <= !row_in_c || (p_c < 0) || (p_c >= top_c);
        idx0_q <= p_c[AW+F-1:F];
        w_q    <= p_c[F-1:0];
      end
      S_RD1: begin
        a_re_q <= rdata[2*S-1:S];
        a_im_q <= rdata[S-1:0];
      end
      S_LERP: begin
        prod_re_q <= mul_re_c;
        prod_im_q <= mul_im_c;
      end
      S_DONE: begin
        if (out_free) begin
          out_data.out_of_range <= oor_q;
          out_data.row_echo     <= row_q;
          out_data.out_re       <= oor_q ? 16'sd0 : 16'($signed(res_re_c));
          out_data.out_im       <= oor_q ? 16'sd0 : 16'($signed(res_im_c));
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("store written and read in the same cycle");

  a_read_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (in_data.command == rmi_pkg::CMD_READ)) |=> !in_ready)
    else $error("input taken while a read is in progress");

  a_oor_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.out_of_range) |-> (out_data.out_re == 0 && out_data.out_im == 0))
    else $error("out-of-range result carries nonzero data");

  a_shift_saturated: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAP) |-> (shift_q <= lim_c))
    else $error("shift exceeds the row limit");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && in_ready))
    else $error("finished read did not reach the output register");
`endif

endmodule
